// File: src/bpa_pkg.sv
// Shared types, constants and codes for the bitmap page allocator.
`default_nettype none

package bpa_pkg;

    // Field widths
    localparam int ADDR_W      = 48;
    localparam int COUNT_W     = 13;
    localparam int STATUS_W    = 3;
    localparam int CFG_INDEX_W = 2;

    // Parameter defaults
    localparam int MAX_PAGES_DEF  = 4096;
    localparam int PAGE_SHIFT_DEF = 12;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LIMIT = 2'd1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_OUT_OF_MEM   = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_NULL_ADDR    = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_ALL_FREE     = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_OUT_OF_RANGE = 3'd4;
    localparam logic [STATUS_W-1:0] STATUS_ALREADY_FREE = 3'd5;

    // Request modes
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [ADDR_W-1:0] page_address;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   result_address;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  free_pages;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic                load;
        logic                rd_scan;
        logic                rd_free;
        logic                wr_alloc;
        logic                wr_free;
        logic                set_err;
        logic [STATUS_W-1:0] err_code;
        logic                emit;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic                is_free;
        logic                alloc_empty;
        logic                free_err;
        logic [STATUS_W-1:0] free_code;
        logic                hit;
        logic                last;
        logic                page_used;
        logic                out_free;
    } stat_t;

endpackage

`default_nettype wire

// File: src/bpa_ctrl.sv
// Sequencer for allocate and free requests of the bitmap page allocator.
`default_nettype none

module bpa_ctrl
    import bpa_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_stall,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_FREE_CHK,
        ST_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   stall_reg;
    logic   stall_next;

    // Decide commands and next state
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (!stat.is_free)
                begin
                    if (stat.alloc_empty)
                    begin
                        cmd.set_err  = 1'b1;
                        cmd.err_code = STATUS_OUT_OF_MEM;
                        state_next   = ST_OUT;
                    end
                    else
                    begin
                        cmd.rd_scan = 1'b1;
                        state_next  = ST_SCAN;
                    end
                end
                else if (stat.free_err)
                begin
                    cmd.set_err  = 1'b1;
                    cmd.err_code = stat.free_code;
                    state_next   = ST_OUT;
                end
                else
                begin
                    cmd.rd_free = 1'b1;
                    state_next  = ST_FREE_CHK;
                end
            end
            ST_SCAN:
            begin
                if (stat.hit)
                begin
                    cmd.wr_alloc = 1'b1;
                    state_next   = ST_OUT;
                end
                else if (stat.last)
                begin
                    cmd.set_err  = 1'b1;
                    cmd.err_code = STATUS_OUT_OF_MEM;
                    state_next   = ST_OUT;
                end
                else
                begin
                    cmd.rd_scan = 1'b1;
                end
            end
            ST_FREE_CHK:
            begin
                if (stat.page_used)
                begin
                    cmd.wr_free = 1'b1;
                end
                else
                begin
                    cmd.set_err  = 1'b1;
                    cmd.err_code = STATUS_ALREADY_FREE;
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        stall_next = (state_next != ST_IDLE);
    end

    // Hold state and the input stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            stall_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stall_reg <= stall_next;
        end
    end

    assign in_stall = stall_reg;

endmodule

`default_nettype wire

// File: src/bpa_dpath.sv
// Datapath of the bitmap page allocator: config, used map, counter, result.
`default_nettype none

module bpa_dpath
    import bpa_pkg::*;
#(
    parameter int MAX_PAGES  = MAX_PAGES_DEF,
    parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire in_item_t               in_item,
    input  wire logic                   cfg_valid,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [ADDR_W-1:0]      cfg_data,
    input  wire logic                   out_stall,
    output logic                        out_valid,
    output out_item_t                   out_item,
    input  wire cmd_t                   cmd,
    output stat_t                       stat
);

    // Only pages below the 13-bit limit are ever reachable
    localparam int MAP_PAGES  = (MAX_PAGES / 64) * 64;
    localparam int USED_PAGES = (MAP_PAGES < 8192) ? MAP_PAGES : 8192;
    localparam int MEM_WORDS  = USED_PAGES / 64;
    localparam int WORD_W     = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

    // Configuration and counter
    logic [ADDR_W-1:0]  base_reg;
    logic [COUNT_W-1:0] limit_reg;
    logic [COUNT_W-1:0] count_reg;

    // Request and scan state
    logic              mode_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [WORD_W-1:0] scan_ptr_reg;
    logic [WORD_W-1:0] data_word_reg;

    // Used map
    logic [63:0]          mem [MEM_WORDS];
    logic [MEM_WORDS-1:0] word_valid_reg;
    logic [63:0]          mem_rd_reg;
    logic                 rd_valid_reg;

    // Result
    logic [ADDR_W-1:0]   res_addr_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic                out_valid_reg;
    out_item_t           out_item_reg;

    logic [COUNT_W-1:0]  lim;
    logic [COUNT_W-1:0]  lim_m1;
    logic [ADDR_W-1:0]   diff;
    logic [ADDR_W-1:0]   page_full;
    logic [COUNT_W-1:0]  free_idx;
    logic                range_bad;
    logic                free_err;
    logic [STATUS_W-1:0] free_code;
    logic [63:0]         rdata;
    logic [63:0]         lim_mask;
    logic [63:0]         free_bits;
    logic [5:0]          hit_bit;
    logic [COUNT_W-1:0]  alloc_idx;
    logic [7:0]          last_word;
    logic [WORD_W-1:0]   rd_word;
    logic                rd_en;
    logic                wr_en;
    logic [63:0]         wr_data;
    logic [5:0]          wr_bit;

    // Clamp the limit to the managed pages
    always_comb
    begin
        if ({1'b0, limit_reg} > 14'(USED_PAGES))
        begin
            lim = COUNT_W'(USED_PAGES);
        end
        else
        begin
            lim = limit_reg;
        end
    end
    assign lim_m1 = lim - 1'b1;

    // Turn the free address into a page index and check it
    assign diff      = addr_reg - base_reg;
    assign page_full = diff >> PAGE_SHIFT;
    assign free_idx  = page_full[COUNT_W-1:0];
    assign range_bad = (addr_reg < base_reg) || (|page_full[ADDR_W-1:COUNT_W])
                       || (free_idx >= lim);

    always_comb
    begin
        free_err  = 1'b1;
        free_code = STATUS_OK;
        if (addr_reg == '0)
        begin
            free_code = STATUS_NULL_ADDR;
        end
        else if (count_reg >= lim)
        begin
            free_code = STATUS_ALL_FREE;
        end
        else if (range_bad)
        begin
            free_code = STATUS_OUT_OF_RANGE;
        end
        else
        begin
            free_err = 1'b0;
        end
    end
    assign stat.free_err  = free_err;
    assign stat.free_code = free_code;

    // Words never written read as all used
    assign rdata = rd_valid_reg ? mem_rd_reg : '1;

    // Mask off pages at or above the limit in the last word
    assign last_word = 8'(lim_m1[COUNT_W-1:6]);
    always_comb
    begin
        if (8'(data_word_reg) < last_word)
        begin
            lim_mask = '1;
        end
        else
        begin
            lim_mask = {64{1'b1}} >> (6'd63 - lim_m1[5:0]);
        end
    end
    assign free_bits = ~rdata & lim_mask;

    // Find the lowest free page of the word
    always_comb
    begin
        hit_bit = '0;
        for (int i = 63; i >= 0; i--)
        begin
            if (free_bits[i])
            begin
                hit_bit = 6'(i);
            end
        end
    end
    assign alloc_idx = COUNT_W'({data_word_reg, hit_bit});

    assign stat.is_free     = (mode_reg == MODE_FREE);
    assign stat.alloc_empty = (count_reg == '0) || (lim == '0);
    assign stat.hit         = |free_bits;
    assign stat.last        = (8'(data_word_reg) == last_word);
    assign stat.page_used   = rdata[free_idx[5:0]];
    assign stat.out_free    = !out_valid_reg || !out_stall;

    // Map port control
    assign rd_en   = cmd.rd_scan || cmd.rd_free;
    assign rd_word = cmd.rd_free ? free_idx[WORD_W+5:6] : scan_ptr_reg;
    assign wr_en   = cmd.wr_alloc || cmd.wr_free;
    assign wr_bit  = cmd.wr_free ? free_idx[5:0] : hit_bit;
    always_comb
    begin
        if (cmd.wr_free)
        begin
            wr_data = rdata & ~(64'd1 << wr_bit);
        end
        else
        begin
            wr_data = rdata | (64'd1 << wr_bit);
        end
    end

    // Read and write the used map
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            mem_rd_reg <= mem[rd_word];
        end
        if (wr_en)
        begin
            mem[data_word_reg] <= wr_data;
        end
    end

    // Track written words; the rest of the map stays all used
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_valid_reg <= '0;
            rd_valid_reg   <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                rd_valid_reg <= word_valid_reg[rd_word];
            end
            if (wr_en)
            begin
                word_valid_reg[data_word_reg] <= 1'b1;
            end
        end
    end

    // Hold config registers and the free count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            limit_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cfg_valid && (cfg_index == CFG_BASE))
            begin
                base_reg <= cfg_data;
            end
            if (cfg_valid && (cfg_index == CFG_LIMIT))
            begin
                limit_reg <= cfg_data[COUNT_W-1:0];
            end
            if (cmd.wr_alloc)
            begin
                count_reg <= count_reg - 1'b1;
            end
            else if (cmd.wr_free)
            begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    // Latch the item and advance the scan
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg     <= in_item.mode;
            addr_reg     <= in_item.page_address;
            scan_ptr_reg <= '0;
        end
        else if (cmd.rd_scan)
        begin
            scan_ptr_reg <= scan_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            data_word_reg <= rd_word;
        end
    end

    // Form the result
    always_ff @(posedge clk)
    begin
        if (cmd.wr_alloc)
        begin
            res_addr_reg   <= base_reg + (ADDR_W'(alloc_idx) << PAGE_SHIFT);
            res_status_reg <= STATUS_OK;
        end
        else if (cmd.wr_free)
        begin
            res_addr_reg   <= '0;
            res_status_reg <= STATUS_OK;
        end
        else if (cmd.set_err)
        begin
            res_addr_reg   <= '0;
            res_status_reg <= cmd.err_code;
        end
        if (cmd.emit)
        begin
            out_item_reg.result_address <= res_addr_reg;
            out_item_reg.status         <= res_status_reg;
            out_item_reg.free_pages     <= count_reg;
        end
    end

    // Hold the output item until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire

// File: src/bitmap_page_allocator_top.sv
// Top level of the first-fit bitmap page allocator.
// Allocate: scans k map words, k = 1 to ceil(limit/64), one word per cycle
// through the map's registered read port. Free: checks the request, then reads
// its map word; rejected requests and an empty pool skip the map. A result held
// by a stalled receiver delays the next; the next item is accepted in the cycle
// after the result is registered. Reset: every page used, count zero.
`default_nettype none

module bitmap_page_allocator_top
    import bpa_pkg::*;
#(
    parameter int MAX_PAGES  = MAX_PAGES_DEF,
    parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire in_item_t               in_item,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output out_item_t                   out_item,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [ADDR_W-1:0]      cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    // Registers take a write in any cycle
    assign cfg_ready = 1'b1;

    bpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    bpa_dpath #(
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_item  (out_item),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

`default_nettype wire

// File: sim/tb.sv
// Self-checking testbench for the bitmap page allocator top level.
`timescale 1ns / 100ps

module tb;
    import bpa_pkg::*;

    localparam int PAGES       = MAX_PAGES_DEF;
    localparam int PAGE_SHIFT  = PAGE_SHIFT_DEF;
    localparam int PHASE_ITEMS = 205;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 80;
    localparam int MAX_LOGGED  = 40;

    // Page frame ledger: tracks the used map and free count, owes one outcome per request
    class frame_ledger;
        logic [ADDR_W-1:0]  base;
        logic [COUNT_W-1:0] limit;
        logic [COUNT_W-1:0] free_cnt;
        bit                 used_pages [PAGES];
        out_item_t          owed_outcomes [$];
        int unsigned        errors;
        int unsigned        status_hits [6];
        int unsigned        outcomes_seen;
        int                 top_page;

        function new();
            base          = '0;
            limit         = '0;
            free_cnt      = '0;
            errors        = 0;
            outcomes_seen = 0;
            top_page      = -1;
            foreach (used_pages[i])
                used_pages[i] = 1'b1;
            foreach (status_hits[i])
                status_hits[i] = 0;
        endfunction

        function int active_pages();
            return (limit > PAGES) ? PAGES : int'(limit);
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [ADDR_W-1:0] data);
            if (idx == CFG_BASE)
                base = data;
            else if (idx == CFG_LIMIT)
                limit = data[COUNT_W-1:0];
        endfunction

        // Apply one accepted request and queue the outcome it must produce
        function void account_request(in_item_t req);
            out_item_t         want;
            int                lim;
            int                idx;
            logic [ADDR_W-1:0] page;
            want = '0;
            lim  = active_pages();
            if (req.mode == MODE_ALLOC) begin
                want.status = STATUS_OUT_OF_MEM;
                if (free_cnt != 0) begin
                    idx = 0;
                    while (idx < lim && used_pages[idx])
                        idx++;
                    if (idx < lim) begin
                        used_pages[idx] = 1'b1;
                        free_cnt        = free_cnt - 1'b1;
                        page            = ADDR_W'(idx);
                        want.status         = STATUS_OK;
                        want.result_address = base + (page << PAGE_SHIFT);
                        if (idx > top_page)
                            top_page = idx;
                    end
                end
            end
            else if (req.page_address == '0)
                want.status = STATUS_NULL_ADDR;
            else if (int'(free_cnt) >= lim)
                want.status = STATUS_ALL_FREE;
            else if (req.page_address < base)
                want.status = STATUS_OUT_OF_RANGE;
            else begin
                // Offset bits inside the page drop out here
                page = (req.page_address - base) >> PAGE_SHIFT;
                if (page >= ADDR_W'(lim))
                    want.status = STATUS_OUT_OF_RANGE;
                else if (!used_pages[page])
                    want.status = STATUS_ALREADY_FREE;
                else begin
                    used_pages[page] = 1'b0;
                    free_cnt         = free_cnt + 1'b1;
                    want.status      = STATUS_OK;
                end
            end
            want.free_pages = free_cnt;
            status_hits[want.status]++;
            owed_outcomes.push_back(want);
        endfunction

        task report_mismatch(string msg);
            errors++;
            // Keep the log short once a design is badly off
            if (errors <= MAX_LOGGED)
                $display("[%0t] mismatch: %s", $time, msg);
        endtask

        // Compare one accepted outcome against the oldest owed one
        task match_outcome(out_item_t got);
            out_item_t want;
            if (owed_outcomes.size() == 0) begin
                report_mismatch($sformatf("unexpected outcome %h", got));
                return;
            end
            want = owed_outcomes.pop_front();
            outcomes_seen++;
            if (got.result_address !== want.result_address)
                report_mismatch($sformatf("result_address %h, want %h",
                                          got.result_address, want.result_address));
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.free_pages !== want.free_pages)
                report_mismatch($sformatf("free_pages %0d, want %0d",
                                          got.free_pages, want.free_pages));
        endtask
    endclass

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    in_item_t               in_item   = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    out_item_t              out_item;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_BASE;
    logic [ADDR_W-1:0]      cfg_data  = '0;

    frame_ledger ledger;
    bit          idle_enable  = 1'b1;
    bit          hold_request = 1'b0;
    int unsigned longest_in_stall = 0;
    int unsigned reg_writes = 0;

    bitmap_page_allocator_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic logic [ADDR_W-1:0] rand_addr();
        return ADDR_W'({$urandom(), $urandom()});
    endfunction

    function automatic logic [ADDR_W-1:0] page_addr(int idx, logic [PAGE_SHIFT-1:0] offset);
        logic [ADDR_W-1:0] page;
        page = ADDR_W'(idx);
        return ledger.base + (page << PAGE_SHIFT) + ADDR_W'(offset);
    endfunction

    // Offer one item, hold it until accepted, then book it
    task automatic request(input logic mode, input logic [ADDR_W-1:0] addr);
        in_item_t    req;
        int unsigned stalled;
        req.mode         = mode;
        req.page_address = addr;
        stalled          = 0;
        while (idle_enable && $urandom_range(99) < 17) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= req;
        @(posedge clk);
        while (in_stall) begin
            stalled++;
            @(posedge clk);
        end
        if (stalled > longest_in_stall)
            longest_in_stall = stalled;
        ledger.account_request(req);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [ADDR_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        ledger.write_reg(idx, data);
        reg_writes++;
        @(posedge clk);
    endtask

    // Drop valid and wait until every owed outcome is back
    task automatic settle();
        in_valid <= 1'b0;
        while (ledger.owed_outcomes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_regs(input logic [ADDR_W-1:0] base_val, input int lim_val);
        settle();
        write_reg(CFG_BASE, base_val);
        write_reg(CFG_LIMIT, ADDR_W'(lim_val));
    endtask

    // Mostly well-formed allocate/free traffic, with some malformed frees mixed in
    task automatic random_request(input bit deep);
        int                    lim;
        int                    target;
        int                    idx;
        int                    pick;
        logic [PAGE_SHIFT-1:0] offset;
        lim    = ledger.active_pages();
        target = (lim / 2 < 48) ? lim / 2 : 48;
        pick   = $urandom_range(99);
        offset = $urandom_range(1) ? PAGE_SHIFT'($urandom()) : '0;
        if (pick < 3)
            request(MODE_FREE, '0);
        else if (pick < 6)
            request(MODE_FREE, (ledger.base == '0) ? rand_addr()
                                                   : ledger.base - 1 - $urandom_range(4095));
        else if (pick < 10)
            request(logic'($urandom_range(1)), rand_addr());
        else if (pick < 13)
            request(MODE_FREE, page_addr(lim + $urandom_range(7), offset));
        else if ($urandom_range(99) < ((int'(ledger.free_cnt) < target) ? 65 : 30)) begin
            if (lim == 0)
                idx = 0;
            else if (deep)
                idx = $urandom_range(lim - 1, lim / 2);
            else
                idx = $urandom_range(lim - 1);
            request(MODE_FREE, page_addr(idx, offset));
        end
        else
            request(MODE_ALLOC, rand_addr());
    endtask

    // Receiver: check outcomes, stall at random, and hold off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (out_valid && !out_stall)
                ledger.match_outcome(out_item);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= idle_enable && ($urandom_range(99) < 17);
        end
    end

    // Stimulus
    initial
    begin
        logic [ADDR_W-1:0] base_val;
        int                lim_val;
        int                wait_cycles;
        ledger = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty pool right after reset
        request(MODE_ALLOC, '0);
        request(MODE_FREE, '0);
        request(MODE_FREE, 48'h1000);

        set_regs(48'h0000_0010_0000, PAGES);
        request(MODE_FREE, 48'h0000_0008_0000);
        request(MODE_FREE, page_addr(PAGES, '0));
        request(MODE_FREE, page_addr(5, 12'h123));
        request(MODE_FREE, page_addr(5, '0));
        request(MODE_FREE, page_addr(PAGES - 1, 12'hfff));
        request(MODE_FREE, page_addr(0, '0));
        request(MODE_ALLOC, '1);
        request(MODE_ALLOC, '0);
        request(MODE_ALLOC, '0);
        request(MODE_ALLOC, '0);
        request(MODE_FREE, '1);
        request(MODE_FREE, page_addr(100, '0));

        // Free page sits above a lowered limit
        settle();
        write_reg(CFG_LIMIT, ADDR_W'(64));
        request(MODE_ALLOC, '0);
        settle();
        write_reg(CFG_LIMIT, ADDR_W'(1));
        request(MODE_FREE, page_addr(0, '0));
        settle();
        write_reg(CFG_LIMIT, '0);
        request(MODE_ALLOC, '0);

        // Address wrap past the top of the address space
        set_regs('0, 16);
        request(MODE_FREE, 48'h1000);
        request(MODE_FREE, 48'h0fff);
        settle();
        write_reg(CFG_BASE, 48'hffff_ffff_f000);
        request(MODE_ALLOC, '0);
        request(MODE_ALLOC, '0);
        request(MODE_FREE, '1);

        // Random phases, one register setting each
        for (int phase = 0; phase < 8; phase++) begin
            base_val = rand_addr();
            base_val[PAGE_SHIFT-1:0] = '0;
            case (phase)
                0:       lim_val = $urandom_range(16, 1);
                1:       lim_val = 64;
                2:       lim_val = 65;
                3:
                begin
                    base_val = '1;
                    lim_val  = $urandom_range(PAGES, 1);
                end
                4:       lim_val = $urandom_range(PAGES, 1);
                5:
                begin
                    base_val = '0;
                    lim_val  = PAGES;
                end
                6:
                begin
                    base_val = rand_addr();
                    lim_val  = PAGES;
                end
                default: lim_val = PAGES - 1;
            endcase
            set_regs(base_val, lim_val);
            idle_enable = (phase != 1);
            if (phase == 2)
                hold_request = 1'b1;
            repeat ((phase == 3) ? PHASE_ITEMS / 2 : PHASE_ITEMS)
                random_request(phase == 6);
        end

        // Drain, with a bound
        in_valid <= 1'b0;
        wait_cycles = 0;
        while (ledger.owed_outcomes.size() != 0 && wait_cycles < 20000) begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (ledger.owed_outcomes.size() != 0)
            ledger.report_mismatch($sformatf("%0d outcomes never arrived",
                                             ledger.owed_outcomes.size()));

        $display("checked %0d outcomes across %0d register writes: ok %0d, no memory %0d,",
                 ledger.outcomes_seen, reg_writes, ledger.status_hits[STATUS_OK],
                 ledger.status_hits[STATUS_OUT_OF_MEM]);
        $display("null %0d, all free %0d, out of range %0d, already free %0d; top page %0d, "
                 , ledger.status_hits[STATUS_NULL_ADDR], ledger.status_hits[STATUS_ALL_FREE],
                 ledger.status_hits[STATUS_OUT_OF_RANGE],
                 ledger.status_hits[STATUS_ALREADY_FREE], ledger.top_page,
                 "longest input stall %0d cycles", longest_in_stall);
        if (ledger.errors == 0)
            $display("bitmap_page_allocator_top regression: pass");
        else
            $display("bitmap_page_allocator_top regression: fail");
        $finish;
    end

    // Watchdog: several times the slowest legal run
    initial
    begin
        #5_000_000;
        $display("bitmap_page_allocator_top regression: fail");
        $finish;
    end

endmodule
